### hdl/nearest_centroid_assign_top_defines.svh
// assertion macros used by the checker file
`ifndef NEAREST_CENTROID_ASSIGN_TOP_DEFINES_SVH
`define NEAREST_CENTROID_ASSIGN_TOP_DEFINES_SVH

// same-cycle implication, skipped while rst is high
`define NCA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nca check failed");

// next-cycle implication, skipped while rst is high
`define NCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nca check failed");

`endif

### hdl/nca_pkg.sv
// shared types and constants for the nearest centroid block
`timescale 1ns / 1ps

package nca_pkg;

  localparam int COUNT_W = 5;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd15;

  typedef enum logic [0:0] {
    CMD_LOAD   = 1'b0,
    CMD_ASSIGN = 1'b1
  } nca_op_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic ram_we;
    logic load_point;
    logic issue;
    logic publish;
  } nca_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic busy;
  } nca_stat_t;

endpackage

### hdl/nca_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module nca_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/nca_dp.sv
// datapath: centroid table, distance pipeline, running minimum, result register
`timescale 1ns / 1ps

module nca_dp import nca_pkg::*; #(
  parameter int MAX_CLUSTERS = 16,
  parameter int COORD_BITS   = 17
) (
  input  logic                            clk,
  input  logic                            rst,
  input  nca_cmd_t                        cmd,
  input  logic [$clog2(MAX_CLUSTERS)-1:0] scan_addr,
  input  logic [$clog2(MAX_CLUSTERS)-1:0] slot,
  input  logic [COORD_BITS-1:0]           coord_x,
  input  logic [COORD_BITS-1:0]           coord_y,
  output nca_stat_t                       stat,
  output logic [$clog2(MAX_CLUSTERS)-1:0] nearest_index,
  output logic [2*COORD_BITS:0]           min_sq_distance
);

  localparam int AW     = $clog2(MAX_CLUSTERS);
  localparam int CW     = COORD_BITS;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = 2 * COORD_BITS + 1;

  logic [2*CW-1:0] rd_data;
  logic [CW-1:0]   cen_x;
  logic [CW-1:0]   cen_y;

  logic [CW-1:0]     pt_x;
  logic [CW-1:0]     pt_y;
  logic              v1, v2, v3;
  logic [AW-1:0]     idx1, idx2, idx3;
  logic [CW-1:0]     dx, dy;
  logic [SQ_W-1:0]   sq_x, sq_y;
  logic [DIST_W-1:0] best_d;
  logic [AW-1:0]     best_k;
  logic [DIST_W-1:0] sum;
  logic              take;

  nca_ram #(
    .WIDTH(2 * CW),
    .DEPTH(MAX_CLUSTERS)
  ) u_table (
    .clk  (clk),
    .we   (cmd.ram_we),
    .waddr(slot),
    .wdata({coord_x, coord_y}),
    .raddr(scan_addr),
    .rdata(rd_data)
  );

  assign cen_x = rd_data[2*CW-1:CW];
  assign cen_y = rd_data[CW-1:0];

  assign sum  = {1'b0, sq_x} + {1'b0, sq_y};
  // first entry seeds the minimum; strict compare keeps the lowest index on ties
  assign take = v3 && ((idx3 == '0) || (sum < best_d));

  assign stat.busy = v1 || v2 || v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      pt_x <= coord_x;
      pt_y <= coord_y;
    end
    idx1 <= scan_addr;
    idx2 <= idx1;
    idx3 <= idx2;
    dx   <= (pt_x >= cen_x) ? (pt_x - cen_x) : (cen_x - pt_x);
    dy   <= (pt_y >= cen_y) ? (pt_y - cen_y) : (cen_y - pt_y);
    sq_x <= SQ_W'(dx) * SQ_W'(dx);
    sq_y <= SQ_W'(dy) * SQ_W'(dy);
    if (take) begin
      best_d <= sum;
      best_k <= idx3;
    end
    if (cmd.publish) begin
      nearest_index   <= best_k;
      min_sq_distance <= best_d;
    end
  end

endmodule

### hdl/nca_ctrl.sv
// controller: handshakes, count register, scan sequencing
`timescale 1ns / 1ps

module nca_ctrl import nca_pkg::*; #(
  parameter int MAX_CLUSTERS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [$clog2(MAX_CLUSTERS)-1:0] slot,
  input  logic                            cfg_wr_en,
  input  logic [COUNT_W-1:0]              cfg_wr_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  input  nca_stat_t                       stat,
  output nca_cmd_t                        cmd,
  output logic [$clog2(MAX_CLUSTERS)-1:0] scan_addr
);

  localparam int AW = $clog2(MAX_CLUSTERS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] cluster_count;
  logic [AW-1:0]      last_addr;
  logic [AW-1:0]      last_addr_next;
  logic               accept;
  logic               slot_ok;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // slots past the table end are dropped
  assign slot_ok  = 32'(slot) < 32'(MAX_CLUSTERS);

  assign cmd.ram_we     = accept && (command == CMD_LOAD) && slot_ok;
  assign cmd.load_point = accept && (command == CMD_ASSIGN);
  assign cmd.issue      = (state == S_SCAN);
  assign cmd.publish    = (state == S_DRAIN) && !stat.busy && (!out_valid || out_ready);

  // zero count scans one entry, oversize count scans the whole table
  always_comb begin
    if (cluster_count == '0) begin
      last_addr_next = '0;
    end else if (32'(cluster_count) > 32'(MAX_CLUSTERS)) begin
      last_addr_next = AW'(MAX_CLUSTERS - 1);
    end else begin
      last_addr_next = AW'(cluster_count - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cluster_count <= COUNT_RESET;
      out_valid     <= 1'b0;
      scan_addr     <= '0;
      last_addr     <= '0;
    end else begin
      if (cfg_wr_en) begin
        cluster_count <= cfg_wr_data;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.load_point) begin
            scan_addr <= '0;
            last_addr <= last_addr_next;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_addr == last_addr) begin
            state <= S_DRAIN;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        S_DRAIN: begin
          if (cmd.publish) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/nearest_centroid_assign_top.sv
// k-means nearest centroid assignment, top level
// Input channel (in_valid/in_ready) carries command, slot, coord_x, coord_y.
// A load command writes the centroid (coord_x, coord_y) into table entry slot
// and gives no result. An assign command scans table entries
// 0 .. n-1, n being cluster_count clamped to 1 .. MAX_CLUSTERS, and returns
// the nearest entry and its squared distance on the output channel
// (out_valid/out_ready); ties go to the lowest index.
// The user must write cluster_count through cfg_wr_en/cfg_wr_data only while
// idle; the block itself does not enforce this. After an assign transfer the
// input stays closed until its result is published; a load leaves it open.
// The scan reads one table entry per cycle through a single ram read port and
// feeds one shared distance unit (diff, square, add-compare stages).
// A finished result sits in the output register; loads are still taken while
// it waits, a following assign scans but holds its result until the
// receiver has taken the earlier one.
// Reset (rst, synchronous) empties the pipeline and output and sets
// cluster_count to 15; table contents are undefined until loaded.
`timescale 1ns / 1ps

module nearest_centroid_assign_top import nca_pkg::*; #(
  parameter int MAX_CLUSTERS = 16,
  parameter int COORD_BITS   = 17
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [$clog2(MAX_CLUSTERS)-1:0] slot,
  input  logic [COORD_BITS-1:0]           coord_x,
  input  logic [COORD_BITS-1:0]           coord_y,
  input  logic                            cfg_wr_en,
  input  logic [COUNT_W-1:0]              cfg_wr_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [$clog2(MAX_CLUSTERS)-1:0] nearest_index,
  output logic [2*COORD_BITS:0]           min_sq_distance
);

  localparam int AW = $clog2(MAX_CLUSTERS);

  nca_cmd_t      cmd;
  nca_stat_t     stat;
  logic [AW-1:0] scan_addr;

  nca_ctrl #(
    .MAX_CLUSTERS(MAX_CLUSTERS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .slot       (slot),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd),
    .scan_addr  (scan_addr)
  );

  nca_dp #(
    .MAX_CLUSTERS(MAX_CLUSTERS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .scan_addr      (scan_addr),
    .slot           (slot),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .stat           (stat),
    .nearest_index  (nearest_index),
    .min_sq_distance(min_sq_distance)
  );

endmodule

### hdl/nca_checker.sv
// port-level checks for the nearest centroid block, bound to the top level
`timescale 1ns / 1ps
`include "nearest_centroid_assign_top_defines.svh"

module nca_checker import nca_pkg::*; #(
  parameter int MAX_CLUSTERS = 16,
  parameter int COORD_BITS   = 17
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            command,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [$clog2(MAX_CLUSTERS)-1:0] nearest_index,
  input logic [2*COORD_BITS:0]           min_sq_distance
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // an assign occupies the block, so the input closes right after its transfer
  `NCA_ASSERT_NEXT(a_assign_busy, clk, rst, in_xfer && (command == CMD_ASSIGN), !in_ready)

  // a load never produces a result
  `NCA_ASSERT_NEXT(a_load_silent, clk, rst, in_xfer && (command == CMD_LOAD) && !out_valid, !out_valid)

  // a stalled result keeps its value
  `NCA_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid && $stable(nearest_index) && $stable(min_sq_distance))

  // reset leaves no result pending
  `NCA_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

endmodule

bind nearest_centroid_assign_top nca_checker #(
  .MAX_CLUSTERS(MAX_CLUSTERS),
  .COORD_BITS  (COORD_BITS)
) u_nca_checker (.*);

### tb/nearest_centroid_assign_top_tb.sv
// self-checking testbench for the nearest centroid assignment block
`timescale 1ns / 1ps

module nearest_centroid_assign_top_tb import nca_pkg::*;;

  localparam int MAX_CLUSTERS  = 16;
  localparam int COORD_BITS    = 17;
  localparam int IDX_W         = $clog2(MAX_CLUSTERS);
  localparam int DIST_W        = 2 * COORD_BITS + 1;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int PHASES        = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 2 * MAX_CLUSTERS;
  localparam int CYCLE_LIMIT   = 400000;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_W-1:0]      index_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef struct packed {
    index_t index;
    dist_t  sq_dist;
  } nearest_t;

  localparam coord_t COORD_MAX = '1;

  class centroid_scoreboard;
    coord_t             cent_x[MAX_CLUSTERS];
    coord_t             cent_y[MAX_CLUSTERS];
    logic [COUNT_W-1:0] count;
    nearest_t           nearest_q[$];
    int                 loads;
    int                 assigns;
    int                 results;
    int                 failures;

    function new();
      count    = COUNT_RESET;
      loads    = 0;
      assigns  = 0;
      results  = 0;
      failures = 0;
      foreach (cent_x[k]) begin
        cent_x[k] = '0;
        cent_y[k] = '0;
      end
    endfunction

    function void set_count(logic [COUNT_W-1:0] value);
      count = value;
    endfunction

    function int pending();
      return nearest_q.size();
    endfunction

    function void report(string msg);
      if (failures < 10) $display("mismatch at %0t: %s", $time, msg);
      failures++;
    endfunction

    // a load only updates the table, an assign scans the active entries
    function void note_input(nca_op_t op, index_t slot_in, coord_t px, coord_t py);
      int       n;
      coord_t   dx;
      coord_t   dy;
      dist_t    d;
      nearest_t best;
      if (op == CMD_LOAD) begin
        cent_x[slot_in] = px;
        cent_y[slot_in] = py;
        loads++;
        return;
      end
      assigns++;
      n = (count == 0) ? 1 : (count > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(count);
      best = '0;
      for (int k = 0; k < n; k++) begin
        dx = (px >= cent_x[k]) ? px - cent_x[k] : cent_x[k] - px;
        dy = (py >= cent_y[k]) ? py - cent_y[k] : cent_y[k] - py;
        d  = dist_t'(dx) * dist_t'(dx) + dist_t'(dy) * dist_t'(dy);
        // strict compare keeps the lowest index on ties
        if (k == 0 || d < best.sq_dist) begin
          best.index   = index_t'(k);
          best.sq_dist = d;
        end
      end
      nearest_q.push_back(best);
    endfunction

    function void check_result(index_t got_index, dist_t got_dist);
      nearest_t want;
      results++;
      if (nearest_q.size() == 0) begin
        report($sformatf("unexpected result index %0d distance %0d", got_index, got_dist));
        return;
      end
      want = nearest_q.pop_front();
      if (got_index !== want.index)
        report($sformatf("nearest_index expected %0d got %0d", want.index, got_index));
      if (got_dist !== want.sq_dist)
        report($sformatf("min_sq_distance expected %0d got %0d", want.sq_dist, got_dist));
    endfunction
  endclass

  centroid_scoreboard sb = new();

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               command;
  index_t             slot;
  coord_t             coord_x;
  coord_t             coord_y;
  logic               cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;
  logic               out_valid;
  logic               out_ready;
  index_t             nearest_index;
  dist_t              min_sq_distance;

  logic rx_want;
  logic rx_hold;
  bit   no_idle = 1'b0;
  int   cycles = 0;

  assign out_ready = rx_want & ~rx_hold;

  nearest_centroid_assign_top #(
    .MAX_CLUSTERS(MAX_CLUSTERS),
    .COORD_BITS  (COORD_BITS)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .slot           (slot),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .nearest_index  (nearest_index),
    .min_sq_distance(min_sq_distance)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // result transfers
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready)
      sb.check_result(nearest_index, min_sq_distance);
  end

  initial begin : receiver
    int gap;
    rx_want <= 1'b0;
    @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        rx_want <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rx_want <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // one long receiver stall so the block backs up and drops in_ready
  initial begin : long_stall
    rx_hold <= 1'b0;
    do @(posedge clk); while (sb.results < 150);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COORD_MAX;
      2, 3, 4: return coord_t'($urandom_range(0, 15));
      default: return coord_t'($urandom_range(0, COORD_MAX));
    endcase
  endfunction

  task automatic send_item(nca_op_t op, index_t s, coord_t x, coord_t y);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= op;
    slot     <= s;
    coord_x  <= x;
    coord_y  <= y;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, s, x, y);
  endtask

  // drain all results, then give a trailing scan time to finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_count(value);
  endtask

  initial begin : stimulus
    logic [COUNT_W-1:0] cnt;
    nca_op_t            op;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    command     <= CMD_LOAD;
    slot        <= '0;
    coord_x     <= '0;
    coord_y     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // count of zero scans entry 0 only
    write_count(5'd0);
    send_item(CMD_LOAD, 4'd0, '0, '0);
    send_item(CMD_ASSIGN, 4'hf, COORD_MAX, COORD_MAX);
    send_item(CMD_ASSIGN, 4'd0, '0, '0);
    send_item(CMD_ASSIGN, 4'd5, COORD_MAX, '0);
    send_item(CMD_LOAD, 4'd0, COORD_MAX, COORD_MAX);
    send_item(CMD_ASSIGN, 4'd0, '0, '0);
    wait_idle();

    // oversized count saturates, fill the whole table
    write_count(5'd31);
    send_item(CMD_LOAD, 4'd1, coord_t'(10), '0);
    send_item(CMD_LOAD, 4'd2, '0, coord_t'(10));
    for (int k = 3; k < MAX_CLUSTERS; k++)
      send_item(CMD_LOAD, index_t'(k), coord_t'(k * 8000), COORD_MAX - coord_t'(k * 7000));
    send_item(CMD_ASSIGN, 4'd0, '0, '0);
    send_item(CMD_ASSIGN, 4'd0, coord_t'(15 * 8000), COORD_MAX - coord_t'(15 * 7000));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0:       cnt = 5'd16;
        1:       cnt = 5'd1;
        2:       cnt = 5'd15;
        3:       cnt = 5'd0;
        4:       cnt = 5'd31;
        default: cnt = 5'($urandom_range(2, 30));
      endcase
      no_idle = (p == 2 || p == 6);
      write_count(cnt);
      repeat (RANDOM_ITEMS / PHASES) begin
        op = ($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_ASSIGN;
        send_item(op, index_t'($urandom_range(0, MAX_CLUSTERS - 1)), pick_coord(), pick_coord());
      end
    end
    no_idle = 1'b0;
    wait_idle();

    $display("covered %0d loads and %0d assigns, %0d results checked, %0d count settings",
             sb.loads, sb.assigns, sb.results, PHASES + 2);
    $display("counts 0, 1, 15, 16 and 31, distance extremes, index ties and a long output stall");
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/nca_pkg.sv
hdl/nca_ram.sv
hdl/nca_dp.sv
hdl/nca_ctrl.sv
hdl/nearest_centroid_assign_top.sv
hdl/nca_checker.sv
tb/nearest_centroid_assign_top_tb.sv
